FILE: rtl/datt_pkg.sv
package datt_pkg;

	localparam int TABLE_ENTRIES = 1024;
	localparam int MOVE_BITS     = 32;
	localparam int AGE_BITS      = 16;

	localparam int INDEX_BITS = $clog2(TABLE_ENTRIES);
	localparam int KEY_W      = 64;
	localparam int DEPTH_W    = 8;
	localparam int SCORE_W    = 32;
	localparam int KIND_W     = 2;
	localparam int MOVE_W     = 32;
	localparam int COUNT_W    = 32;

	typedef enum logic [1:0] {
		OP_PROBE    = 2'd0,
		OP_STORE    = 2'd1,
		OP_BEGIN    = 2'd2,
		OP_NEW_GAME = 2'd3
	} op_t;

	typedef struct packed {
		logic [KEY_W-1:0]          key;
		logic [DEPTH_W-1:0]        depth;
		logic signed [SCORE_W-1:0] score;
		logic [KIND_W-1:0]         kind;
		logic [MOVE_BITS-1:0]      move;
		logic [AGE_BITS-1:0]       age;
	} slot_t;

endpackage

FILE: rtl/datt_if.sv
interface datt_req_if;
	logic                                 valid;
	logic                                 ready;
	logic [1:0]                           op;
	logic [datt_pkg::KEY_W-1:0]           position_key;
	logic [datt_pkg::DEPTH_W-1:0]         search_depth;
	logic signed [datt_pkg::SCORE_W-1:0]  score;
	logic [datt_pkg::KIND_W-1:0]          bound_kind;
	logic [datt_pkg::MOVE_W-1:0]          best_move_code;
	logic                                 cancelled;

	modport source (
		output valid, op, position_key, search_depth, score, bound_kind,
		       best_move_code, cancelled,
		input  ready
	);
	modport sink (
		input  valid, op, position_key, search_depth, score, bound_kind,
		       best_move_code, cancelled,
		output ready
	);
endinterface

interface datt_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 key_match;
	logic                                 usable;
	logic [datt_pkg::DEPTH_W-1:0]         entry_depth;
	logic signed [datt_pkg::SCORE_W-1:0]  entry_score;
	logic [datt_pkg::KIND_W-1:0]          entry_kind;
	logic [datt_pkg::MOVE_W-1:0]          entry_move;
	logic                                 written;
	logic [datt_pkg::COUNT_W-1:0]         store_count;

	modport source (
		output valid, key_match, usable, entry_depth, entry_score, entry_kind,
		       entry_move, written, store_count,
		input  ready
	);
	modport sink (
		input  valid, key_match, usable, entry_depth, entry_score, entry_kind,
		       entry_move, written, store_count,
		output ready
	);
endinterface

FILE: rtl/depth_age_transposition_table_unit.sv
// Direct-mapped transposition table with depth/age replacement.
// Channels: "in" (datt_req_if sink) takes one op per transfer: probe, store,
// begin search or new game. "out" (datt_rsp_if source) returns exactly one
// response per op, in order.
// A transferred request is registered in stage 1; when stage 1 advances,
// its response is registered and out.valid rises. Throughput: one op per
// cycle while out.ready is high; the slot read of stage 1 and the
// conditional slot write of stage 2 use separate read and write ports of
// the table memory, with a bypass so back-to-back ops on the same slot
// see the newest entry. Reset: arst_n clears the age, the store count and
// the pipeline, then a clearing pass writes zero to all TABLE_ENTRIES
// slots, one per cycle; in.ready stays low until the pass ends.
// Stall: when out.ready is low the response register holds, stage 1 holds,
// and in.ready drops once stage 1 is full. No op is dropped or repeated.
// The age and the store count are updated when an op leaves stage 1, so
// store_count reports the count after that op.
module depth_age_transposition_table_unit (
	input  logic       clk,
	input  logic       arst_n,
	datt_req_if.sink   in,
	datt_rsp_if.source out
);

	localparam int IW = datt_pkg::INDEX_BITS;

	datt_pkg::slot_t mem [datt_pkg::TABLE_ENTRIES];

	logic                            clearing_q;
	logic [IW-1:0]                   clr_idx_q;

	logic                            v_s1;
	datt_pkg::op_t                   op_s1;
	logic [datt_pkg::KEY_W-1:0]      key_s1;
	logic [datt_pkg::DEPTH_W-1:0]    depth_s1;
	logic signed [datt_pkg::SCORE_W-1:0] score_s1;
	logic [datt_pkg::KIND_W-1:0]     kind_s1;
	logic [datt_pkg::MOVE_BITS-1:0]  move_s1;
	logic                            canc_s1;
	datt_pkg::slot_t                 rd_s1;
	logic                            byp_s1;
	datt_pkg::slot_t                 byp_entry_s1;

	logic [datt_pkg::AGE_BITS-1:0]   age_q;
	logic [datt_pkg::COUNT_W-1:0]    count_q;

	logic                            out_v_q;
	logic                            match_q;
	logic                            usable_q;
	logic [datt_pkg::DEPTH_W-1:0]    depth_q;
	logic signed [datt_pkg::SCORE_W-1:0] score_q;
	logic [datt_pkg::KIND_W-1:0]     kind_q;
	logic [datt_pkg::MOVE_W-1:0]     move_q;
	logic                            written_q;

	logic                            adv;
	logic                            in_xfer;
	logic [IW-1:0]                   in_idx;
	logic [IW-1:0]                   s1_idx;
	datt_pkg::slot_t                 slot;
	datt_pkg::slot_t                 new_entry;
	logic                            hit;
	logic                            do_store;
	logic                            wr_en;
	logic [IW-1:0]                   wr_idx;
	datt_pkg::slot_t                 wr_entry;
	logic [datt_pkg::AGE_BITS-1:0]   age_d;
	logic [datt_pkg::COUNT_W-1:0]    count_d;

	assign adv      = v_s1 && (!out_v_q || out.ready);
	assign in.ready = !clearing_q && (!v_s1 || adv);
	assign in_xfer  = in.valid && in.ready;
	assign in_idx   = in.position_key[IW-1:0];
	assign s1_idx   = key_s1[IW-1:0];

	assign slot = byp_s1 ? byp_entry_s1 : rd_s1;
	assign hit  = slot.key == key_s1;

	always_comb begin
		new_entry.key   = key_s1;
		new_entry.depth = depth_s1;
		new_entry.score = score_s1;
		new_entry.kind  = kind_s1;
		new_entry.move  = move_s1;
		new_entry.age   = age_q;
	end

	assign do_store = (op_s1 == datt_pkg::OP_STORE) && !canc_s1 &&
		((age_q > slot.age) || (slot.depth <= depth_s1));

	assign wr_en    = clearing_q || (adv && do_store);
	assign wr_idx   = clearing_q ? clr_idx_q : s1_idx;
	assign wr_entry = clearing_q ? datt_pkg::slot_t'('0) : new_entry;

	always_comb begin
		age_d   = age_q;
		count_d = count_q;
		unique case (op_s1)
			datt_pkg::OP_PROBE: begin
			end
			datt_pkg::OP_STORE: begin
				if (do_store && count_q != {datt_pkg::COUNT_W{1'b1}})
					count_d = count_q + 1'b1;
			end
			datt_pkg::OP_BEGIN: begin
				if (age_q != {datt_pkg::AGE_BITS{1'b1}})
					age_d = age_q + 1'b1;
			end
			datt_pkg::OP_NEW_GAME: begin
				age_d   = '0;
				count_d = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_idx] <= wr_entry;
		if (in_xfer)
			rd_s1 <= mem[in_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
			v_s1       <= 1'b0;
			age_q      <= '0;
			count_q    <= '0;
			out_v_q    <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == {IW{1'b1}})
					clearing_q <= 1'b0;
			end
			if (in_xfer)
				v_s1 <= 1'b1;
			else if (adv)
				v_s1 <= 1'b0;
			if (adv) begin
				age_q   <= age_d;
				count_q <= count_d;
				out_v_q <= 1'b1;
			end else if (out.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_s1        <= datt_pkg::op_t'(in.op);
			key_s1       <= in.position_key;
			depth_s1     <= in.search_depth;
			score_s1     <= in.score;
			kind_s1      <= in.bound_kind;
			move_s1      <= in.best_move_code[datt_pkg::MOVE_BITS-1:0];
			canc_s1      <= in.cancelled;
			byp_s1       <= adv && do_store && (s1_idx == in_idx);
			byp_entry_s1 <= new_entry;
		end
		if (adv) begin
			match_q   <= 1'b0;
			usable_q  <= 1'b0;
			depth_q   <= '0;
			score_q   <= '0;
			kind_q    <= '0;
			move_q    <= '0;
			written_q <= do_store;
			if (op_s1 == datt_pkg::OP_PROBE && hit) begin
				match_q  <= 1'b1;
				usable_q <= slot.depth >= depth_s1;
				depth_q  <= slot.depth;
				score_q  <= slot.score;
				kind_q   <= slot.kind;
				move_q   <= datt_pkg::MOVE_W'(slot.move);
			end
		end
	end

	assign out.valid       = out_v_q;
	assign out.key_match   = match_q;
	assign out.usable      = usable_q;
	assign out.entry_depth = depth_q;
	assign out.entry_score = score_q;
	assign out.entry_kind  = kind_q;
	assign out.entry_move  = move_q;
	assign out.written     = written_q;
	assign out.store_count = count_q;

endmodule

FILE: rtl/datt_checker.sv
module datt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        key_match,
	input logic        usable,
	input logic        written,
	input logic [7:0]  entry_depth,
	input logic [31:0] entry_score,
	input logic [1:0]  entry_kind,
	input logic [31:0] entry_move
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("response dropped while stalled");

	a_usable_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && usable |-> key_match)
		else $error("usable without key match");

	a_write_not_probe: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && written |-> !key_match && !usable)
		else $error("write flag on a probe response");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !key_match |->
			entry_depth == 8'd0 && entry_score == 32'd0 &&
			entry_kind == 2'd0 && entry_move == 32'd0)
		else $error("entry fields not zero on miss");

endmodule

bind depth_age_transposition_table_unit datt_checker u_datt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out.valid),
	.out_ready   (out.ready),
	.key_match   (out.key_match),
	.usable      (out.usable),
	.written     (out.written),
	.entry_depth (out.entry_depth),
	.entry_score (out.entry_score),
	.entry_kind  (out.entry_kind),
	.entry_move  (out.entry_move)
);
